### hw/rtl/ir_pulse_distance_decoder_defines.svh
// Assertion macros shared by the infrared decoder RTL.
// Every macro assumes a clock named clock and a synchronous reset named reset.
`ifndef IR_PULSE_DISTANCE_DECODER_DEFINES_SVH
`define IR_PULSE_DISTANCE_DECODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPD_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ipd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IPD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ipd assertion failed");

`endif

### hw/rtl/ipd_pkg.sv
// Shared types, codes and reset constants of the infrared pulse-distance decoder.
// Used by every module of the block; depends on nothing.
`default_nettype none

package ipd_pkg;

   localparam int FRAME_BITS_DEFAULT   = 32;
   localparam int REPEAT_LIMIT_DEFAULT = 250;
   localparam int QUEUE_DEPTH          = 2;

   localparam int CSR_COUNT   = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int TICK_W      = 16;
   localparam int CODE_W      = 32;
   localparam int TALLY_W     = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LEADER_MIN = 3'd0,
      CSR_LEADER_MAX = 3'd1,
      CSR_ZERO_MIN   = 3'd2,
      CSR_ZERO_MAX   = 3'd3,
      CSR_ONE_MIN    = 3'd4,
      CSR_ONE_MAX    = 3'd5,
      CSR_REPEAT_MIN = 3'd6,
      CSR_REPEAT_MAX = 3'd7
   } csr_index_type;

   localparam logic [TICK_W-1:0] CSR_RESET [CSR_COUNT] = '{
      16'd11612, 16'd13456, 16'd921, 16'd1198,
      16'd1843, 16'd2396, 16'd9216, 16'd14746
   };

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_LEADER = 2'd1,
      PH_BITS   = 2'd2,
      PH_REPEAT = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ST_BUSY   = 2'd0,
      ST_FRAME  = 2'd1,
      ST_REPEAT = 2'd2,
      ST_ERROR  = 2'd3
   } status_type;

   // Window matches of one edge interval, worked out when the edge is taken.
   typedef struct packed {
      logic in_leader;
      logic in_zero;
      logic in_one;
      logic in_repeat;
   } class_type;

   typedef struct packed {
      status_type          status;
      logic [CODE_W-1:0]   code;
      logic [TALLY_W-1:0]  repeats;
   } rsp_type;

endpackage

`default_nettype wire

### hw/rtl/ipd_fifo.sv
// Small first-in first-out queue of registers with full and empty flags.
// Depends on ipd_pkg for its default depth and on the assertion macro header.
`default_nettype none
`include "ir_pulse_distance_decoder_defines.svh"

module ipd_fifo import ipd_pkg::*; #(
   parameter int WIDTH = 1,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   // Pointers wrap naturally since the depth is a power of two.
   assign wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in  = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = entry_ff[rd_ptr_ff];

   `IPD_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= CNT_W'(DEPTH))
   `IPD_ASSERT_SAME(a_ptr_gap, !full, PTR_W'(wr_ptr_ff - rd_ptr_ff) == PTR_W'(count_ff))
   `IPD_ASSERT_NEXT(a_push_pop_level, do_push && do_pop, $stable(count_ff))

endmodule

`default_nettype wire

### hw/rtl/ipd_front.sv
// Front end: holds the window registers and classes each accepted edge interval.
// Depends on ipd_pkg for the register indexes, reset values and the class record.
`default_nettype none

module ipd_front import ipd_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire logic [TICK_W-1:0]      interval,
   output logic                        full,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [TICK_W-1:0]      csr_wdata,
   output logic                        cls_push,
   output class_type                   cls_item,
   input  wire logic                   cls_full
);

   logic [TICK_W-1:0] window_ff [CSR_COUNT];

   function automatic logic in_window(
      input logic [TICK_W-1:0] v,
      input logic [TICK_W-1:0] lo,
      input logic [TICK_W-1:0] hi
   );
      return (v >= lo) && (v <= hi);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= CSR_RESET;
      end else if (csr_we) begin
         window_ff[csr_index] <= csr_wdata;
      end
   end

   // The windows do not depend on the decoder phase, so every edge is classed
   // here and the phase logic downstream only picks the match it needs.
   always_comb begin
      cls_item.in_leader = in_window(interval, window_ff[CSR_LEADER_MIN],
                                     window_ff[CSR_LEADER_MAX]);
      cls_item.in_zero   = in_window(interval, window_ff[CSR_ZERO_MIN],
                                     window_ff[CSR_ZERO_MAX]);
      cls_item.in_one    = in_window(interval, window_ff[CSR_ONE_MIN],
                                     window_ff[CSR_ONE_MAX]);
      cls_item.in_repeat = in_window(interval, window_ff[CSR_REPEAT_MIN],
                                     window_ff[CSR_REPEAT_MAX]);
   end

   assign full     = cls_full;
   assign cls_push = push & ~cls_full;

endmodule

`default_nettype wire

### hw/rtl/ipd_back.sv
// Back end: the frame state machine that turns classed edges into results.
// Depends on ipd_pkg for the phase, status and record types, and on the macro header.
`default_nettype none
`include "ir_pulse_distance_decoder_defines.svh"

module ipd_back import ipd_pkg::*; #(
   parameter int FRAME_BITS   = FRAME_BITS_DEFAULT,
   parameter int REPEAT_LIMIT = REPEAT_LIMIT_DEFAULT
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      cls_empty,
   input  wire class_type cls_item,
   output logic           cls_pop,
   input  wire logic      rsp_full,
   output logic           rsp_push,
   output rsp_type        rsp_item
);

   localparam int BITS_W = $clog2(FRAME_BITS + 1);
   localparam logic [BITS_W-1:0]  LAST_BIT = BITS_W'(FRAME_BITS - 1);
   localparam logic [CODE_W-1:0]  FRAME_MASK = CODE_W'((64'd1 << FRAME_BITS) - 64'd1);
   localparam logic [TALLY_W-1:0] TALLY_LIMIT = TALLY_W'(REPEAT_LIMIT);

   phase_type          phase_ff, phase_in;
   logic [CODE_W-1:0]  code_ff, code_in;
   logic [BITS_W-1:0]  bits_ff, bits_in;
   logic [TALLY_W-1:0] tally_ff, tally_in;
   status_type         status;
   logic               step;

   assign step     = ~cls_empty & ~rsp_full;
   assign cls_pop  = step;
   assign rsp_push = step;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         code_ff  <= '0;
         bits_ff  <= '0;
         tally_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         code_ff  <= code_in;
         bits_ff  <= bits_in;
         tally_ff <= tally_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      code_in  = code_ff;
      bits_in  = bits_ff;
      tally_in = tally_ff;
      status   = ST_BUSY;
      if (step) begin
         unique case (phase_ff)
            PH_IDLE: begin
               phase_in = PH_LEADER;
            end
            PH_LEADER: begin
               code_in = '0;
               bits_in = '0;
               if (cls_item.in_leader) begin
                  phase_in = PH_BITS;
               end else begin
                  phase_in = PH_IDLE;
                  status   = ST_ERROR;
               end
            end
            PH_BITS: begin
               if (cls_item.in_zero || cls_item.in_one) begin
                  // The zero window wins when both windows match.
                  code_in = {code_ff[CODE_W-2:0], ~cls_item.in_zero} & FRAME_MASK;
                  if (bits_ff == LAST_BIT) begin
                     status   = ST_FRAME;
                     phase_in = PH_REPEAT;
                     bits_in  = '0;
                     tally_in = '0;
                  end else begin
                     bits_in = bits_ff + 1'b1;
                  end
               end else begin
                  phase_in = PH_IDLE;
                  code_in  = '0;
                  bits_in  = '0;
                  status   = ST_ERROR;
               end
            end
            PH_REPEAT: begin
               if (cls_item.in_repeat) begin
                  if (tally_ff < TALLY_LIMIT) begin
                     tally_in = tally_ff + 1'b1;
                  end
                  status = ST_REPEAT;
               end else begin
                  phase_in = PH_LEADER;
               end
            end
         endcase
      end
      rsp_item = '{status: status, code: code_in, repeats: tally_in};
   end

   `IPD_ASSERT_NEXT(a_frame_enters_repeat, rsp_push && rsp_item.status == ST_FRAME,
                    phase_ff == PH_REPEAT && tally_ff == '0)
   `IPD_ASSERT_SAME(a_bits_cleared, phase_ff != PH_BITS, bits_ff == '0)
   `IPD_ASSERT_SAME(a_state_bounded, 1'b1,
                    tally_ff <= TALLY_LIMIT && (code_ff & ~FRAME_MASK) == '0)

endmodule

`default_nettype wire

### hw/rtl/ir_pulse_distance_decoder.sv
// Throughput: one edge per cycle while full is low; the front classes edges against
// the window registers, a two-beat queue feeds the frame state machine, and a
// two-beat result queue lets either side stall alone. Full is the full flag of the
// edge queue, which fills when the result queue backs up.
// Reset (synchronous) empties both queues, returns to idle, clears the frame
// and repeat count, and loads the default window registers.
`default_nettype none

module ir_pulse_distance_decoder import ipd_pkg::*; #(
   parameter int FRAME_BITS   = FRAME_BITS_DEFAULT,
   parameter int REPEAT_LIMIT = REPEAT_LIMIT_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   output logic                        full,
   input  wire logic [TICK_W-1:0]      req_interval,
   output logic                        empty,
   input  wire logic                   pop,
   output logic [1:0]                  rsp_status,
   output logic [CODE_W-1:0]           rsp_code,
   output logic [TALLY_W-1:0]          rsp_repeats,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [TICK_W-1:0]      csr_wdata
);

   class_type                   front_item, back_item;
   logic [$bits(class_type)-1:0] cls_head;
   logic                        cls_push, cls_full, cls_empty, cls_pop;
   rsp_type                     back_rsp, head_rsp;
   logic [$bits(rsp_type)-1:0]  rsp_head;
   logic                        rsp_push, rsp_full;

   ipd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .interval  (req_interval),
      .full      (full),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cls_push  (cls_push),
      .cls_item  (front_item),
      .cls_full  (cls_full)
   );

   ipd_fifo #(
      .WIDTH ($bits(class_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_cls_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cls_push),
      .push_data (front_item),
      .full      (cls_full),
      .pop       (cls_pop),
      .pop_data  (cls_head),
      .empty     (cls_empty)
   );

   assign back_item = class_type'(cls_head);

   ipd_back #(
      .FRAME_BITS   (FRAME_BITS),
      .REPEAT_LIMIT (REPEAT_LIMIT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cls_empty (cls_empty),
      .cls_item  (back_item),
      .cls_pop   (cls_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_item  (back_rsp)
   );

   ipd_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (back_rsp),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_head),
      .empty     (empty)
   );

   assign head_rsp    = rsp_type'(rsp_head);
   assign rsp_status  = head_rsp.status;
   assign rsp_code    = head_rsp.code;
   assign rsp_repeats = head_rsp.repeats;

endmodule

`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for the infrared pulse-distance decoder.
// Feeds edge intervals through several window settings and checks every result beat
// against an in-bench decoder model; depends only on ipd_pkg and the RTL.
module testbench import ipd_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CODE_W-1:0] FRAME_MASK = (FRAME_BITS_DEFAULT >= CODE_W) ?
      {CODE_W{1'b1}} : ((CODE_W'(1) << FRAME_BITS_DEFAULT) - CODE_W'(1));

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  push = 1'b0;
   logic                  full;
   logic [TICK_W-1:0]     req_interval = '0;
   logic                  empty;
   logic                  pop = 1'b0;
   logic [1:0]            rsp_status;
   logic [CODE_W-1:0]     rsp_code;
   logic [TALLY_W-1:0]    rsp_repeats;
   logic                  csr_we = 1'b0;
   csr_index_type         csr_index = CSR_LEADER_MIN;
   logic [TICK_W-1:0]     csr_wdata = '0;

   // Decoder model state and its copy of the window registers.
   phase_type             dec_phase = PH_IDLE;
   logic [CODE_W-1:0]     dec_code = '0;
   logic [5:0]            dec_bits = '0;
   logic [TALLY_W-1:0]    dec_tally = '0;
   logic [TICK_W-1:0]     window_reg [CSR_COUNT];
   logic [TICK_W-1:0]     next_windows [CSR_COUNT];

   logic [TICK_W-1:0]     edge_intervals [$];
   rsp_type               expected_decodes [$];
   rsp_type               due_rsp;
   int                    edges_queued = 0;
   int                    edges_taken = 0;
   int                    mismatches = 0;
   int                    send_gap_pct = 8;
   int                    recv_gap_pct = 66;
   logic                  rsp_hold = 1'b0;
   bit                    hold_request = 1'b0;
   bit                    gen_armed = 1'b0;

   ir_pulse_distance_decoder i_dut (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_interval (req_interval),
      .empty        (empty),
      .pop          (pop),
      .rsp_status   (rsp_status),
      .rsp_code     (rsp_code),
      .rsp_repeats  (rsp_repeats),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic bit in_window(logic [TICK_W-1:0] v, int lo_idx);
      return v >= window_reg[lo_idx] && v <= window_reg[lo_idx + 1];
   endfunction

   function automatic rsp_type decode_edge(logic [TICK_W-1:0] iv);
      rsp_type r;
      logic    bit_value;
      r.status = ST_BUSY;
      case (dec_phase)
         PH_IDLE: begin
            dec_phase = PH_LEADER;
         end
         PH_LEADER: begin
            if (in_window(iv, CSR_LEADER_MIN)) begin
               dec_phase = PH_BITS;
            end else begin
               dec_phase = PH_IDLE;
               r.status = ST_ERROR;
            end
            dec_code = '0;
            dec_bits = '0;
         end
         PH_BITS: begin
            if (in_window(iv, CSR_ZERO_MIN) || in_window(iv, CSR_ONE_MIN)) begin
               // The zero window wins where the two windows overlap.
               bit_value = !in_window(iv, CSR_ZERO_MIN);
               dec_code = {dec_code[CODE_W-2:0], bit_value} & FRAME_MASK;
               dec_bits = dec_bits + 6'd1;
               if (dec_bits >= FRAME_BITS_DEFAULT) begin
                  r.status = ST_FRAME;
                  dec_phase = PH_REPEAT;
                  dec_bits = '0;
                  dec_tally = '0;
               end
            end else begin
               dec_phase = PH_IDLE;
               dec_code = '0;
               dec_bits = '0;
               r.status = ST_ERROR;
            end
         end
         default: begin
            if (in_window(iv, CSR_REPEAT_MIN)) begin
               if (dec_tally < REPEAT_LIMIT_DEFAULT) begin
                  dec_tally = dec_tally + 8'd1;
               end
               r.status = ST_REPEAT;
            end else begin
               dec_phase = PH_LEADER;
            end
         end
      endcase
      r.code = dec_code;
      r.repeats = dec_tally;
      return r;
   endfunction

   // Sender: takes the beat on a handshake and offers the next one from the queue.
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            expected_decodes.push_back(decode_edge(req_interval));
            edges_taken++;
         end
         if (!push || !full) begin
            if (edge_intervals.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               push <= 1'b1;
               req_interval <= edge_intervals.pop_front();
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each result beat against the oldest expectation.
   always @(posedge clock) begin
      pop <= !rsp_hold && $urandom_range(99) >= recv_gap_pct;
      if (!reset && pop && !empty) begin
         if (expected_decodes.size() == 0) begin
            $error("result beat with nothing expected: status %0d code %h repeats %0d",
                   rsp_status, rsp_code, rsp_repeats);
            mismatches++;
         end else begin
            due_rsp = expected_decodes.pop_front();
            if (rsp_status !== due_rsp.status) begin
               $error("status: expected %0d, got %0d", due_rsp.status, rsp_status);
               mismatches++;
            end
            if (rsp_code !== due_rsp.code) begin
               $error("code: expected %h, got %h", due_rsp.code, rsp_code);
               mismatches++;
            end
            if (rsp_repeats !== due_rsp.repeats) begin
               $error("repeats: expected %0d, got %0d", due_rsp.repeats, rsp_repeats);
               mismatches++;
            end
         end
      end
   end

   function automatic void add_edge(logic [TICK_W-1:0] v);
      edge_intervals.push_back(v);
      edges_queued++;
   endfunction

   function automatic logic [TICK_W-1:0] pick_in(int lo_idx);
      logic [TICK_W-1:0] lo;
      logic [TICK_W-1:0] hi;
      lo = window_reg[lo_idx];
      hi = window_reg[lo_idx + 1];
      if (lo > hi) begin
         return TICK_W'($urandom_range(65535, 0));
      end
      case ($urandom_range(3))
         0: return lo;
         1: return hi;
         default: return TICK_W'($urandom_range(hi, lo));
      endcase
   endfunction

   // Prefers values just outside the window; gives up on windows that cover everything.
   function automatic logic [TICK_W-1:0] pick_out(int lo_idx, int alt_idx);
      logic [TICK_W-1:0] v;
      for (int tries = 0; tries < 8; tries++) begin
         case ($urandom_range(2))
            0: v = window_reg[lo_idx] - 16'd1;
            1: v = window_reg[lo_idx + 1] + 16'd1;
            default: v = TICK_W'($urandom_range(65535, 0));
         endcase
         if (!in_window(v, lo_idx) && (alt_idx < 0 || !in_window(v, alt_idx))) begin
            return v;
         end
      end
      return TICK_W'($urandom_range(65535, 0));
   endfunction

   function automatic void add_frame(int repeat_edges);
      if (!gen_armed) begin
         add_edge(TICK_W'($urandom_range(65535, 0)));
      end
      add_edge(pick_in(CSR_LEADER_MIN));
      for (int i = 0; i < FRAME_BITS_DEFAULT; i++) begin
         add_edge($urandom_range(1) ? pick_in(CSR_ONE_MIN) : pick_in(CSR_ZERO_MIN));
      end
      for (int i = 0; i < repeat_edges; i++) begin
         add_edge(pick_in(CSR_REPEAT_MIN));
      end
      // A stray edge after the repeats re-arms leader timing.
      add_edge(pick_out(CSR_REPEAT_MIN, -1));
      gen_armed = 1'b1;
   endfunction

   function automatic void add_sequence();
      int kind;
      kind = $urandom_range(99);
      if (kind < 75) begin
         add_frame($urandom_range(4));
      end else if (kind < 92) begin
         if (!gen_armed) begin
            add_edge(TICK_W'($urandom_range(65535, 0)));
         end
         if ($urandom_range(3) == 0) begin
            add_edge(pick_out(CSR_LEADER_MIN, -1));
         end else begin
            add_edge(pick_in(CSR_LEADER_MIN));
            for (int i = $urandom_range(FRAME_BITS_DEFAULT - 1); i > 0; i--) begin
               add_edge($urandom_range(1) ? pick_in(CSR_ONE_MIN) : pick_in(CSR_ZERO_MIN));
            end
            add_edge(pick_out(CSR_ZERO_MIN, CSR_ONE_MIN));
         end
         gen_armed = 1'b0;
      end else begin
         for (int i = $urandom_range(6, 1); i > 0; i--) begin
            add_edge(TICK_W'($urandom_range(65535, 0)));
         end
         gen_armed = 1'b0;
      end
   endfunction

   function automatic void fill_to(int target);
      while (edges_queued < target) begin
         add_sequence();
      end
   endfunction

   task automatic load_windows();
      for (int i = 0; i < CSR_COUNT; i++) begin
         @(posedge clock);
         csr_we <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_wdata <= next_windows[i];
         window_reg[i] = next_windows[i];
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Sampled on the falling edge so that nothing races the handshake logic.
   task automatic wait_quiet();
      do begin
         @(negedge clock);
      end while (edges_taken != edges_queued || expected_decodes.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   function automatic void random_windows(bit overlap_bits);
      int lo;
      for (int i = 0; i < CSR_COUNT; i += 2) begin
         lo = int'($urandom_range(60000, 0));
         next_windows[i] = TICK_W'(lo);
         next_windows[i + 1] = TICK_W'(lo + int'($urandom_range(5000, 0)));
      end
      if (overlap_bits) begin
         lo = int'($urandom_range(60000, 0));
         next_windows[CSR_ZERO_MIN] = TICK_W'(lo);
         next_windows[CSR_ZERO_MAX] = TICK_W'(lo + 200);
         next_windows[CSR_ONE_MIN]  = TICK_W'(lo + 100);
         next_windows[CSR_ONE_MAX]  = TICK_W'(lo + 400);
      end
   endfunction

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   // Long receiver hold-off so that both queues fill and the block stalls its input.
   initial begin
      wait (hold_request);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (400) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      window_reg = CSR_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Default windows: leader rejections on both sides, bit window edges, bad bits.
      add_edge(16'hFFFF);
      add_edge(16'd11611);
      add_edge(16'h0000);
      add_edge(16'd13457);
      add_edge(16'h5555);
      add_edge(16'd11612);
      add_edge(16'd921);
      add_edge(16'd1198);
      add_edge(16'd1843);
      add_edge(16'd2396);
      add_edge(16'd920);
      add_edge(16'hAAAA);
      add_edge(16'd13456);
      add_edge(16'd1199);
      add_edge(16'd1);
      add_edge(16'd12000);
      add_edge(16'd2397);
      fill_to(260);
      wait_quiet();

      random_windows(1'b0);
      load_windows();
      fill_to(500);
      wait_quiet();

      // Every window covers the whole range.
      send_gap_pct = 66;
      recv_gap_pct = 8;
      for (int i = 0; i < CSR_COUNT; i += 2) begin
         next_windows[i] = 16'h0000;
         next_windows[i + 1] = 16'hFFFF;
      end
      load_windows();
      gen_armed = 1'b0;
      fill_to(650);
      wait_quiet();

      // Single-value windows at the extremes and windows that match nothing.
      next_windows = '{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
                       16'd40000, 16'd30000, 16'd1, 16'd0};
      load_windows();
      gen_armed = 1'b0;
      fill_to(800);
      wait_quiet();

      random_windows(1'b1);
      load_windows();
      gen_armed = 1'b0;
      fill_to(1050);
      wait_quiet();

      // Defaults again, no idling, a saturating repeat run and the long hold-off.
      send_gap_pct = 0;
      recv_gap_pct = 0;
      next_windows = CSR_RESET;
      load_windows();
      gen_armed = 1'b0;
      add_frame(REPEAT_LIMIT_DEFAULT + 10);
      fill_to(1450);
      hold_request = 1'b1;
      wait_quiet();

      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

### ir_pulse_distance_decoder.f
+incdir+hw/rtl
hw/rtl/ipd_pkg.sv
hw/rtl/ipd_fifo.sv
hw/rtl/ipd_front.sv
hw/rtl/ipd_back.sv
hw/rtl/ir_pulse_distance_decoder.sv
sim/testbench.sv
